[sv/chr_pkg.sv]
// Shared definitions for the consistent hash ring block: opcodes, status codes
// and default sizing. No dependencies.
package chr_pkg;

  // Default number of virtual node slots in the ring memory
  localparam int unsigned RingNodesDef = 1024;

  // Field widths
  localparam int unsigned HashW    = 32;
  localparam int unsigned BackendW = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;

  // Item opcodes
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT = 2'd1;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] ST_HIT   = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_DONE  = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd3;

endpackage

[sv/consistent_hash_ring.sv]
// Consistent hash ring: sorted node memory with binary-search lookup and
// ordered insert. Depends on chr_pkg.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, opcode_i, node_hash_i,   | input
//           | node_backend_i, lookup_key_i                    |
//   out     | out_valid_o/out_ready_i, backend_o, status_o    | output
//
// One item is worked on at a time; the next is taken once the result sits in
// the output register. A lookup does one memory read per search step on the
// single read port, then reads the found slot. An insert runs the search steps,
// moves each node above the insert point up one slot and writes the new node.
// Reset clears the node count, sequencer state and output valid; the node memory
// needs no clearing pass. A stalled output holds its item.
module consistent_hash_ring #(
  parameter int unsigned RING_NODES = chr_pkg::RingNodesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [chr_pkg::OpW-1:0]        opcode_i,
  input  logic [chr_pkg::HashW-1:0]      node_hash_i,
  input  logic [chr_pkg::BackendW-1:0]   node_backend_i,
  input  logic [chr_pkg::HashW-1:0]      lookup_key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [chr_pkg::BackendW-1:0]   backend_o,
  output logic [chr_pkg::StatusW-1:0]    status_o
);

  localparam int unsigned IW = (RING_NODES > 1) ? $clog2(RING_NODES) : 1;
  localparam int unsigned CW = $clog2(RING_NODES + 1);
  localparam int unsigned DW = chr_pkg::HashW + chr_pkg::BackendW;
  localparam logic [CW-1:0] Full = CW'(RING_NODES);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHRD  = 3'd2;
  localparam logic [2:0] S_SHWR  = 3'd3;
  localparam logic [2:0] S_LREAD = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]                   ptr_q, ptr_d, pos_q, pos_d;
  logic                            strict_q, strict_d;
  logic [chr_pkg::HashW-1:0]       key_q, key_d;
  logic [chr_pkg::BackendW-1:0]    nb_q, nb_d;
  logic [chr_pkg::BackendW-1:0]    res_backend_q, res_backend_d;
  logic [chr_pkg::StatusW-1:0]     res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [chr_pkg::BackendW-1:0]    backend_q, backend_d;
  logic [chr_pkg::StatusW-1:0]     status_q, status_d;

  // Node memory: {hash, backend} per slot
  logic [DW-1:0]                   mem [RING_NODES];
  logic [DW-1:0]                   rdata_q;
  logic                            mem_we, mem_re;
  logic [IW-1:0]                   mem_waddr, mem_raddr;
  logic [DW-1:0]                   mem_wdata;

  // Search step helpers
  logic [chr_pkg::HashW-1:0]       rd_hash;
  logic                            go_right;
  logic [CW-1:0]                   lo_n, hi_n, mid_n, found;
  logic                            in_acc, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign rd_hash  = rdata_q[DW-1:chr_pkg::BackendW];
  assign go_right = strict_q ? (rd_hash <= key_q) : (rd_hash < key_q);
  assign lo_n     = go_right ? (mid_q + CW'(1)) : lo_q;
  assign hi_n     = go_right ? hi_q : mid_q;
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);
  assign found    = (lo_n >= count_q) ? '0 : lo_n;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    ptr_d         = ptr_q;
    pos_d         = pos_q;
    strict_d      = strict_q;
    key_d         = key_q;
    nb_d          = nb_q;
    res_backend_d = res_backend_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    backend_d     = backend_q;
    status_d      = status_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          strict_d      = (opcode_i == chr_pkg::OP_INSERT);
          key_d         = (opcode_i == chr_pkg::OP_INSERT) ? node_hash_i : lookup_key_i;
          nb_d          = node_backend_i;
          res_backend_d = '0;
          res_status_d  = chr_pkg::ST_DONE;
          lo_d          = '0;
          hi_d          = count_q;
          mid_d         = count_q >> 1;
          state_d       = S_DONE;
          case (opcode_i)
            chr_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            chr_pkg::OP_INSERT: begin
              if (count_q == Full) begin
                res_status_d = chr_pkg::ST_FULL;
              end else if (count_q == '0) begin
                ptr_d   = '0;
                pos_d   = '0;
                state_d = S_SHRD;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = mid_d[IW-1:0];
                state_d   = S_SRCH;
              end
            end
            chr_pkg::OP_LOOKUP: begin
              if (count_q == '0) begin
                res_status_d = chr_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = mid_d[IW-1:0];
                state_d   = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end

      // One search step per cycle: compare the slot read last cycle
      S_SRCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (lo_n < hi_n) begin
          mem_re    = 1'b1;
          mem_raddr = mid_n[IW-1:0];
        end else if (strict_q) begin
          pos_d   = lo_n;
          ptr_d   = count_q;
          state_d = S_SHRD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = found[IW-1:0];
          state_d   = S_LREAD;
        end
      end

      // Move nodes up one slot from the top, then drop the new node in
      S_SHRD: begin
        if (ptr_q == pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[IW-1:0];
          mem_wdata = {key_q, nb_q};
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(ptr_q - CW'(1));
          state_d   = S_SHWR;
        end
      end

      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[IW-1:0];
        mem_wdata = rdata_q;
        ptr_d     = ptr_q - CW'(1);
        state_d   = S_SHRD;
      end

      S_LREAD: begin
        res_backend_d = rdata_q[chr_pkg::BackendW-1:0];
        res_status_d  = chr_pkg::ST_HIT;
        state_d       = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          backend_d   = res_backend_q;
          status_d    = res_status_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    ptr_q         <= ptr_d;
    pos_q         <= pos_d;
    strict_q      <= strict_d;
    key_q         <= key_d;
    nb_q          <= nb_d;
    res_backend_q <= res_backend_d;
    res_status_q  <= res_status_d;
    backend_q     <= backend_d;
    status_q      <= status_d;
  end

  // Node memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign backend_o   = backend_q;
  assign status_o    = status_q;

endmodule

[sv/chr_checker.sv]
// Port-level checks for consistent_hash_ring, bound to the top level.
// Depends on chr_pkg.
module chr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [chr_pkg::OpW-1:0]      opcode_i,
  input logic [chr_pkg::HashW-1:0]    node_hash_i,
  input logic [chr_pkg::BackendW-1:0] node_backend_i,
  input logic [chr_pkg::HashW-1:0]    lookup_key_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [chr_pkg::BackendW-1:0] backend_o,
  input logic [chr_pkg::StatusW-1:0]  status_o
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Items taken but whose result has not yet been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(backend_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only a lookup hit carries a backend
  a_backend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != chr_pkg::ST_HIT |-> backend_o == '0)
    else $error("non-zero backend on a non-hit result");

  // One item in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("item taken while another is in work");

  // No result without an item behind it, and no more than two outstanding
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> pend_q != 2'd0) and (pend_q != 2'd3))
    else $error("result count does not match items taken");

endmodule

bind consistent_hash_ring chr_checker u_chr_checker (.*);
